// ===== rtl/mex_pkg.sv =====
// ----------------------------------------------------------------------------
// mex_pkg
// Types and constants shared by the modular exponentiation core.
// ----------------------------------------------------------------------------
package mex_pkg;

   localparam int DataWidth  = 31;
   localparam int CountWidth = $clog2(DataWidth);

   localparam logic [DataWidth-1:0] ModulusReset = 31'd1000000007;

   typedef enum logic [5:0] {
      S_IDLE       = 6'b000001,
      S_REDUCE_GO  = 6'b000010,
      S_REDUCE_WT  = 6'b000100,
      S_STEP       = 6'b001000,
      S_MUL_WT     = 6'b010000,
      S_FINISH     = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      SEL_REDUCE = 2'd0,
      SEL_ACC    = 2'd1,
      SEL_SQUARE = 2'd2
   } sel_type;

   typedef struct packed {
      logic    load;
      logic    mul_start;
      logic    write_back;
      sel_type sel;
      logic    out_load;
   } cmd_type;

   typedef struct packed {
      logic exp_zero;
      logic exp_odd;
      logic mul_done;
      logic mod_small;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/mex_mulmod.sv =====
// ----------------------------------------------------------------------------
// mex_mulmod
// Bit-serial interleaved modular multiplier: one multiplier bit a cycle,
// MSB first, partial result kept below the modulus.
// ----------------------------------------------------------------------------
module mex_mulmod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mex_pkg::DataWidth-1:0] op_a,
   input  logic [mex_pkg::DataWidth-1:0] op_b,
   input  logic [mex_pkg::DataWidth-1:0] modulus,
   output logic [mex_pkg::DataWidth-1:0] product,
   output logic                          done
);

   localparam int W = mex_pkg::DataWidth;

   logic [W-1:0]                   a_ff, a_in;
   logic [W-1:0]                   b_ff, b_in;
   logic [W-1:0]                   acc_ff, acc_in;
   logic [mex_pkg::CountWidth-1:0] count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [W+1:0] sum;
   logic [W+1:0] m1;
   logic [W+1:0] m2;
   logic [W+1:0] red;

   always_comb begin
      sum = {1'b0, acc_ff, 1'b0} + (a_ff[W-1] ? {2'b00, b_ff} : '0);
      m1  = {2'b00, modulus};
      m2  = {1'b0, modulus, 1'b0};
      if (sum >= m2) begin
         red = sum - m2;
      end else if (sum >= m1) begin
         red = sum - m1;
      end else begin
         red = sum;
      end
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = op_a;
         b_in     = op_b;
         acc_in   = '0;
         count_in = mex_pkg::CountWidth'(W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in   = red[W-1:0];
         a_in     = {a_ff[W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule

// ===== rtl/mex_datapath.sv =====
// ----------------------------------------------------------------------------
// mex_datapath
// Operand registers, modulus register, serial multiplier and result beat.
// ----------------------------------------------------------------------------
module mex_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mex_pkg::cmd_type              cmd,
   output mex_pkg::status_type           status,
   input  logic [mex_pkg::DataWidth-1:0] req_base_value,
   input  logic [mex_pkg::DataWidth-1:0] req_exponent,
   input  logic                          csr_write,
   input  logic [mex_pkg::DataWidth-1:0] csr_modulus,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [mex_pkg::DataWidth-1:0] rsp_power_result
);

   localparam int W = mex_pkg::DataWidth;

   logic [W-1:0] mod_ff, mod_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] bas_ff, bas_in;
   logic [W-1:0] exp_ff, exp_in;
   logic         out_valid_ff, out_valid_in;
   logic [W-1:0] out_data_ff, out_data_in;

   logic [W-1:0] op_a;
   logic [W-1:0] op_b;
   logic [W-1:0] product;
   logic         mul_done;
   logic         mod_small;

   assign mod_small = (mod_ff < W'(2));

   always_comb begin
      case (cmd.sel)
         mex_pkg::SEL_REDUCE: begin
            op_a = bas_ff;
            op_b = W'(1);
         end
         mex_pkg::SEL_ACC: begin
            op_a = acc_ff;
            op_b = bas_ff;
         end
         mex_pkg::SEL_SQUARE: begin
            op_a = bas_ff;
            op_b = bas_ff;
         end
         default: begin
            op_a = bas_ff;
            op_b = bas_ff;
         end
      endcase
   end

   mex_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .modulus (mod_ff),
      .product (product),
      .done    (mul_done)
   );

   always_comb begin
      mod_in       = csr_write ? csr_modulus : mod_ff;
      acc_in       = acc_ff;
      bas_in       = bas_ff;
      exp_in       = exp_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd.load) begin
         acc_in = W'(1);
         bas_in = req_base_value;
         exp_in = req_exponent;
      end
      if (cmd.write_back) begin
         case (cmd.sel)
            mex_pkg::SEL_REDUCE: bas_in = product;
            mex_pkg::SEL_ACC: begin
               acc_in = product;
               exp_in = exp_ff - 1'b1;
            end
            mex_pkg::SEL_SQUARE: begin
               bas_in = product;
               exp_in = {1'b0, exp_ff[W-1:1]};
            end
            default: bas_in = bas_ff;
         endcase
      end
      if (cmd.out_load) begin
         out_data_in  = mod_small ? '0 : acc_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff       <= mex_pkg::ModulusReset;
         out_valid_ff <= 1'b0;
      end else begin
         mod_ff       <= mod_in;
         out_valid_ff <= out_valid_in;
      end
      acc_ff      <= acc_in;
      bas_ff      <= bas_in;
      exp_ff      <= exp_in;
      out_data_ff <= out_data_in;
   end

   assign status.exp_zero  = (exp_ff == '0);
   assign status.exp_odd   = exp_ff[0];
   assign status.mul_done  = mul_done;
   assign status.mod_small = mod_small;
   assign status.out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid        = out_valid_ff;
   assign rsp_power_result = out_data_ff;

endmodule

// ===== rtl/mex_control.sv =====
// ----------------------------------------------------------------------------
// mex_control
// Sequencer for square-and-multiply: picks multiply or square per step and
// hands the finished value to the result register.
// ----------------------------------------------------------------------------
module mex_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  mex_pkg::status_type status,
   output mex_pkg::cmd_type    cmd,
   output logic                idle
);

   mex_pkg::state_type state_ff, state_in;
   mex_pkg::sel_type   sel_ff, sel_in;

   always_comb begin
      state_in       = state_ff;
      sel_in         = sel_ff;
      cmd.load       = 1'b0;
      cmd.mul_start  = 1'b0;
      cmd.write_back = 1'b0;
      cmd.sel        = sel_ff;
      cmd.out_load   = 1'b0;
      case (state_ff)
         mex_pkg::S_IDLE: begin
            if (req_accept) begin
               cmd.load = 1'b1;
               state_in = mex_pkg::S_REDUCE_GO;
            end
         end
         mex_pkg::S_REDUCE_GO: begin
            if (status.mod_small) begin
               state_in = mex_pkg::S_FINISH;
            end else begin
               cmd.sel       = mex_pkg::SEL_REDUCE;
               cmd.mul_start = 1'b1;
               sel_in        = mex_pkg::SEL_REDUCE;
               state_in      = mex_pkg::S_REDUCE_WT;
            end
         end
         mex_pkg::S_REDUCE_WT, mex_pkg::S_MUL_WT: begin
            if (status.mul_done) begin
               cmd.write_back = 1'b1;
               state_in       = mex_pkg::S_STEP;
            end
         end
         mex_pkg::S_STEP: begin
            if (status.exp_zero) begin
               state_in = mex_pkg::S_FINISH;
            end else begin
               sel_in        = status.exp_odd ? mex_pkg::SEL_ACC : mex_pkg::SEL_SQUARE;
               cmd.sel       = sel_in;
               cmd.mul_start = 1'b1;
               state_in      = mex_pkg::S_MUL_WT;
            end
         end
         mex_pkg::S_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = mex_pkg::S_IDLE;
            end
         end
         default: state_in = mex_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mex_pkg::S_IDLE;
         sel_ff   <= mex_pkg::SEL_REDUCE;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   assign idle = (state_ff == mex_pkg::S_IDLE);

endmodule

// ===== rtl/modular_exponentiation_core.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Base raised to an exponent modulo a programmable modulus, by
// square-and-multiply over a bit-serial modular multiplier.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_base_value, req_exponent
//   rsp      out  rsp_valid/rsp_stall  rsp_power_result
//   csr      in   csr_valid/csr_ready  csr_modulus
//
// One item at a time. Each modular multiply is a start, 31 serial steps and a
// write-back; an item takes one base reduction plus one multiply per set
// exponent bit and one square per halving, at most 61 steps.
// Reset sets the modulus to 1000000007 and clears the result beat.
// A stalled result waits in its register; the block stalls at the end of the
// next item until that register is free.
// ----------------------------------------------------------------------------
module modular_exponentiation_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mex_pkg::DataWidth-1:0] req_base_value,
   input  logic [mex_pkg::DataWidth-1:0] req_exponent,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mex_pkg::DataWidth-1:0] rsp_power_result,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mex_pkg::DataWidth-1:0] csr_modulus
);

   mex_pkg::cmd_type    cmd;
   mex_pkg::status_type status;
   logic                idle;
   logic                req_accept;

   assign req_stall  = !idle;
   assign req_accept = req_valid && idle;
   assign csr_ready  = 1'b1;

   mex_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .status     (status),
      .cmd        (cmd),
      .idle       (idle)
   );

   mex_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_base_value   (req_base_value),
      .req_exponent     (req_exponent),
      .csr_write        (csr_valid && csr_ready),
      .csr_modulus      (csr_modulus),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result)
   );

endmodule

// ===== rtl/mex_checker.sv =====
// ----------------------------------------------------------------------------
// mex_checker
// Port-level checks for the modular exponentiation core.
// ----------------------------------------------------------------------------
module mex_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [mex_pkg::DataWidth-1:0] rsp_power_result
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power_result))
      else $error("stalled result beat changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("not busy after accepted request");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result beat straight after request");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_power_result != {mex_pkg::DataWidth{1'b1}})
      else $error("result not below modulus");

endmodule

bind modular_exponentiation_core mex_checker u_mex_checker (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_exponentiation_core. Request beats are
// priced against a square-and-multiply predictor that uses full-width products.
// Each result beat is checked in order against that prediction. The run goes
// through a series of moduli, the extremes among them, and switches the
// pacing of both channels from phase to phase.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DataWidth = mex_pkg::DataWidth;
   localparam logic [DataWidth-1:0] ModulusReset = mex_pkg::ModulusReset;
   localparam int unsigned CycleLimit = 20_000_000;
   localparam logic [DataWidth-1:0] Ones = '1;

   typedef enum int {
      PACE_NONE,
      PACE_SENDER,
      PACE_RECEIVER,
      PACE_BOTH
   } pacing_type;

   typedef struct {
      logic [DataWidth-1:0] base;
      logic [DataWidth-1:0] exponent;
      logic [DataWidth-1:0] power;
   } power_entry_type;

   class power_scoreboard;
      logic [DataWidth-1:0] modulus;
      power_entry_type      expected_powers[$];
      int                   mismatches;

      function new();
         modulus    = ModulusReset;
         mismatches = 0;
      endfunction

      function logic [DataWidth-1:0] power_mod(logic [DataWidth-1:0] base,
                                               logic [DataWidth-1:0] exponent);
         logic [63:0]          acc;
         logic [63:0]          sq;
         logic [63:0]          m;
         logic [DataWidth-1:0] e;
         if (modulus < 2) return '0;
         m   = {33'd0, modulus};
         acc = 64'd1;
         sq  = {33'd0, base} % m;
         e   = exponent;
         while (e != 0) begin
            if (e[0]) begin
               acc = (acc * sq) % m;
               e   = e - 1'b1;
            end else begin
               sq = (sq * sq) % m;
               e  = e >> 1;
            end
         end
         return acc[DataWidth-1:0];
      endfunction

      function void note_request(logic [DataWidth-1:0] base,
                                 logic [DataWidth-1:0] exponent);
         power_entry_type entry;
         entry.base     = base;
         entry.exponent = exponent;
         entry.power    = power_mod(base, exponent);
         expected_powers.push_back(entry);
      endfunction

      function void check_power(logic [DataWidth-1:0] actual);
         power_entry_type entry;
         if (expected_powers.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result beat: power_result %0d", actual);
            mismatches++;
         end else begin
            entry = expected_powers.pop_front();
            if (actual !== entry.power) begin
               if (mismatches < 10)
                  $display("base %0d exp %0d mod %0d: expected %0d, got %0d",
                           entry.base, entry.exponent, modulus, entry.power, actual);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_powers.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [DataWidth-1:0] req_base_value = '0;
   logic [DataWidth-1:0] req_exponent = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DataWidth-1:0] rsp_power_result;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [DataWidth-1:0] csr_modulus = '0;

   pacing_type      pacing = PACE_NONE;
   int unsigned     cycle_count = 0;
   power_scoreboard sb = new();

   modular_exponentiation_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_base_value   (req_base_value),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_modulus      (csr_modulus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("modular_exponentiation_core: mismatch");
         $finish;
      end
   end

   function automatic bit sender_gap();
      case (pacing)
         PACE_SENDER: return $urandom_range(99) < 59;
         PACE_BOTH:   return $urandom_range(99) < 34;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_gap();
      case (pacing)
         PACE_RECEIVER: return $urandom_range(99) < 59;
         PACE_BOTH:     return $urandom_range(99) < 34;
         default:       return 1'b0;
      endcase
   endfunction

   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : receiver_gap();
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_power(rsp_power_result);
   end

   task automatic send_request(input logic [DataWidth-1:0] base,
                               input logic [DataWidth-1:0] exponent);
      @(negedge clock);
      while (sender_gap()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_base_value <= base;
      req_exponent   <= exponent;
      do @(posedge clock); while (req_stall);
      sb.note_request(base, exponent);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [DataWidth-1:0] value);
      @(negedge clock);
      req_valid   <= 1'b0;
      csr_valid   <= 1'b1;
      csr_modulus <= value;
      do @(posedge clock); while (!csr_ready);
      sb.modulus = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_item();
      logic [DataWidth-1:0] base;
      logic [DataWidth-1:0] exponent;
      logic [DataWidth-1:0] m;
      logic [31:0]          mask;
      m = sb.modulus;
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(4))
            0: base = '0;
            1: base = 1;
            2: base = Ones;
            3: base = m;
            default: base = m - 1'b1;
         endcase
      end else begin
         base = DataWidth'($urandom());
      end
      case ($urandom_range(15))
         0: exponent = DataWidth'($urandom());
         1: begin
            case ($urandom_range(6))
               0: exponent = '0;
               1: exponent = 1;
               2: exponent = 2;
               3: exponent = Ones;
               4: exponent = m - 1'b1;
               5: exponent = m - 2'd2;
               default: exponent = 31'h4000_0000;
            endcase
         end
         default: begin
            mask     = (32'd1 << $urandom_range(10, 1)) - 1;
            exponent = DataWidth'($urandom() & mask);
         end
      endcase
      send_request(base, exponent);
   endtask

   task automatic run_phase(input logic [DataWidth-1:0] value, input int count,
                            input pacing_type pace);
      drain_results();
      write_modulus(value);
      pacing = pace;
      for (int i = 0; i < count; i++) begin
         // hold off once midway through the phase until every result is back
         if (i == count / 2) drain_results();
         send_random_item();
      end
   endtask

   initial begin
      logic [DataWidth-1:0] p;
      p = ModulusReset;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request('0, '0);
      send_request('0, 1);
      send_request('0, Ones);
      send_request(Ones, '0);
      send_request(Ones, 1);
      send_request(Ones, Ones);
      send_request(1, Ones);
      send_request(2, 10);
      send_request(p, 5);
      send_request(p + 1'b1, 3);
      send_request(3, p - 2'd2);
      send_request(7, p - 1'b1);
      send_request(12345, 2);
      send_request(2, 31'h4000_0000);
      send_request(31'h5555_5555, 31'h2AAA_AAAA);
      send_request(31'h2AAA_AAAA, 31'h5555_5555);
      for (int i = 0; i < 140; i++) send_random_item();

      run_phase(Ones, 140, PACE_SENDER);
      run_phase(2, 60, PACE_RECEIVER);
      run_phase('0, 30, PACE_BOTH);
      run_phase(1, 30, PACE_NONE);
      run_phase(DataWidth'($urandom()) | 31'h4000_0000, 140, PACE_RECEIVER);
      run_phase(65537, 140, PACE_BOTH);
      run_phase(DataWidth'($urandom_range(1000, 3)), 140, PACE_SENDER);
      run_phase(p, 140, PACE_BOTH);
      run_phase(DataWidth'($urandom()), 140, PACE_RECEIVER);
      run_phase(Ones, 120, PACE_SENDER);
      run_phase(3, 60, PACE_NONE);

      @(negedge clock);
      req_valid <= 1'b0;
      drain_results();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("modular_exponentiation_core: match");
      else
         $display("modular_exponentiation_core: mismatch");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mex_pkg.sv
rtl/mex_mulmod.sv
rtl/mex_datapath.sv
rtl/mex_control.sv
rtl/modular_exponentiation_core.sv
rtl/mex_checker.sv
verif/testbench.sv
